### rtl/lnso_pkg.sv
// shared types and constants for the scale-only layer normalization block
// no dependencies
package lnso_pkg;

    localparam int LANES     = 8;
    localparam int LANE_SH   = 3;
    localparam int VAL_W     = 16;
    localparam int SUM_W     = 25;
    localparam int RL_W      = 9;
    localparam logic [RL_W-1:0] RL_RESET = 9'd384;
    localparam int MEAN_W    = SUM_W - LANE_SH;
    localparam int D_W       = MEAN_W + 1;
    localparam int MAG_W     = D_W - 1;
    localparam int SQL_W     = 2 * MAG_W;
    localparam int RSTD_W    = 25;
    localparam int P1_W      = MAG_W + RSTD_W;
    localparam int LIM_SHIFT = 48;
    localparam int LIM_W     = LIM_SHIFT + 1;
    localparam int VAR_W     = SQL_W;
    localparam int DVR_W     = VAR_W + 1;

    localparam logic OP_SCALE = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    typedef struct packed {
        logic valid;
        logic emit;
        logic last;
    } lnso_tag_t;

    typedef struct packed {
        logic en;
        logic emit;
    } lnso_lane_ctl_t;

endpackage

### rtl/lnso_lane.sv
// one lane core: deviation, shared multiplier for square or scaling, rounding
// depends on lnso_pkg
module lnso_lane (
    input  logic                                  clk,
    input  lnso_pkg::lnso_lane_ctl_t              ctl,
    input  logic signed [lnso_pkg::VAL_W-1:0]     x,
    input  logic signed [lnso_pkg::VAL_W-1:0]     w,
    input  logic signed [lnso_pkg::MEAN_W-1:0]    mean,
    input  logic        [lnso_pkg::RSTD_W-1:0]    rstd,
    output logic        [lnso_pkg::SQL_W-1:0]     sq,
    output logic signed [lnso_pkg::VAL_W-1:0]     norm
);
    import lnso_pkg::*;

    logic signed [D_W-1:0] d;
    logic [MAG_W-1:0]  dmag_next;
    logic [VAL_W-1:0]  wmag_next;
    logic [MAG_W-1:0]  dmag_reg;
    logic              dneg_reg;
    logic [VAL_W-1:0]  wmag_reg;
    logic              wneg_reg;
    logic [RSTD_W-1:0] opb;
    logic [P1_W-1:0]   p1_next;
    logic [P1_W-1:0]   p1_reg;
    logic              neg3_reg;
    logic [VAL_W-1:0]  wmag3_reg;
    logic [39:0]       plo_next;
    logic [38:0]       phi_next;
    logic [39:0]       plo_reg;
    logic [38:0]       phi_reg;
    logic              neg4_reg;
    logic [63:0]       p2;
    logic [63:0]       rnd;
    logic [35:0]       mag;

    assign d         = D_W'(x) - D_W'(mean);
    assign dmag_next = d[D_W-1] ? MAG_W'(-d) : MAG_W'(d);
    assign wmag_next = w[VAL_W-1] ? VAL_W'(-w) : VAL_W'(w);

    assign opb     = ctl.emit ? rstd : RSTD_W'(dmag_reg);
    assign p1_next = P1_W'(dmag_reg) * P1_W'(opb);

    assign plo_next = 40'(p1_reg[23:0]) * 40'(wmag3_reg);
    assign phi_next = 39'(p1_reg[P1_W-1:24]) * 39'(wmag3_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            dmag_reg  <= dmag_next;
            dneg_reg  <= d[D_W-1];
            wmag_reg  <= wmag_next;
            wneg_reg  <= w[VAL_W-1];
            p1_reg    <= p1_next;
            neg3_reg  <= dneg_reg ^ wneg_reg;
            wmag3_reg <= wmag_reg;
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
            neg4_reg  <= neg3_reg;
        end
    end

    assign sq  = p1_reg[SQL_W-1:0];
    assign p2  = {1'b0, phi_reg, 24'b0} + 64'(plo_reg);
    assign rnd = p2 + (64'(1) << 27);
    assign mag = rnd[63:28];

    always_comb
    begin
        if (neg4_reg)
        begin
            if (mag > 36'd32768)
                norm = 16'sh8000;
            else
                norm = VAL_W'(-mag);
        end
        else
        begin
            if (mag > 36'd32767)
                norm = 16'sh7fff;
            else
                norm = mag[VAL_W-1:0];
        end
    end

endmodule

### rtl/lnso_merge.sv
// merge stage: adds the lane squares of a group and accumulates over the row
// depends on lnso_pkg
module lnso_merge #(
    parameter int SQ_W = 53
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          clear,
    input  lnso_pkg::lnso_tag_t           tag,
    input  logic [lnso_pkg::SQL_W-1:0]    sq [lnso_pkg::LANES],
    output logic [SQ_W-1:0]               acc,
    output logic                          done
);
    import lnso_pkg::*;

    logic [SQ_W-1:0] tree_next;
    logic [SQ_W-1:0] tree_reg;
    logic            tv_reg;
    logic            tl_reg;
    logic [SQ_W-1:0] acc_reg;
    logic            done_reg;

    always_comb
    begin
        tree_next = '0;
        for (int i = 0; i < LANES; i++)
            tree_next = tree_next + SQ_W'(sq[i]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            tree_reg <= tree_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg   <= 1'b0;
            tl_reg   <= 1'b0;
            acc_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                tv_reg <= tag.valid && !tag.emit;
                tl_reg <= tag.last;
            end
            if (clear)
            begin
                acc_reg  <= '0;
                done_reg <= 1'b0;
            end
            else if (en && tv_reg)
            begin
                acc_reg <= acc_reg + tree_reg;
                if (tl_reg)
                    done_reg <= 1'b1;
            end
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

### rtl/lnso_div.sv
// restoring unsigned divider, one quotient bit per cycle
// no dependencies
module lnso_div #(
    parameter int DVD_W = 53,
    parameter int DVR_W = 45
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVR_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] q_reg;
    logic [DVR_W-1:0] rem_reg;
    logic [DVR_W-1:0] dvr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVR_W:0]   rem_sh;
    logic [DVR_W:0]   diff;
    logic             ge;

    assign rem_sh = {rem_reg, q_reg[DVD_W-1]};
    assign diff   = rem_sh - {1'b0, dvr_reg};
    assign ge     = !diff[DVR_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            q_reg    <= '0;
            rem_reg  <= '0;
            dvr_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                q_reg    <= dividend;
                rem_reg  <= '0;
                dvr_reg  <= divisor;
                cnt_reg  <= CNT_W'(DVD_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                q_reg   <= {q_reg[DVD_W-2:0], ge};
                rem_reg <= ge ? diff[DVR_W-1:0] : rem_sh[DVR_W-1:0];
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

### rtl/lnso_isqrt.sv
// digit-by-digit integer square root, one result bit per cycle
// depends on lnso_pkg
module lnso_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lnso_pkg::LIM_W-1:0]    radicand,
    output logic                          done,
    output logic [lnso_pkg::RSTD_W-1:0]   root
);
    import lnso_pkg::*;

    logic [LIM_W-1:0] op_reg;
    logic [LIM_W-1:0] res_reg;
    logic [LIM_W-1:0] bit_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [LIM_W-1:0] trial;
    logic             ge;

    assign trial = res_reg + bit_reg;
    assign ge    = op_reg >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= '0;
            res_reg  <= '0;
            bit_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                op_reg   <= radicand;
                res_reg  <= '0;
                bit_reg  <= LIM_W'(1) << (LIM_W - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (ge)
                begin
                    op_reg  <= op_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0])
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[RSTD_W-1:0];

endmodule

### rtl/layer_normalization_scale_only.sv
// row flow: a row-ending item starts the mean division, the variance pass and division, the limit
// division and the root, run on the shared divider and root (DVD_W = 53 at 384 elements);
// then its G results follow, first group to last (G = groups per row)
// throughput: one item per cycle except during the row pass; input is held off from the
// row-ending item until the last group is issued
// reset: asynchronous active low; counters, sum and row_length (384) reset, stores undefined
module layer_normalization_scale_only #(
    parameter int MAX_ROW_LENGTH = 384
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lnso_pkg::RL_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               operation,
    input  logic signed [lnso_pkg::VAL_W-1:0]  value_0,
    input  logic signed [lnso_pkg::VAL_W-1:0]  value_1,
    input  logic signed [lnso_pkg::VAL_W-1:0]  value_2,
    input  logic signed [lnso_pkg::VAL_W-1:0]  value_3,
    input  logic signed [lnso_pkg::VAL_W-1:0]  value_4,
    input  logic signed [lnso_pkg::VAL_W-1:0]  value_5,
    input  logic signed [lnso_pkg::VAL_W-1:0]  value_6,
    input  logic signed [lnso_pkg::VAL_W-1:0]  value_7,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [lnso_pkg::VAL_W-1:0]  norm_0,
    output logic signed [lnso_pkg::VAL_W-1:0]  norm_1,
    output logic signed [lnso_pkg::VAL_W-1:0]  norm_2,
    output logic signed [lnso_pkg::VAL_W-1:0]  norm_3,
    output logic signed [lnso_pkg::VAL_W-1:0]  norm_4,
    output logic signed [lnso_pkg::VAL_W-1:0]  norm_5,
    output logic signed [lnso_pkg::VAL_W-1:0]  norm_6,
    output logic signed [lnso_pkg::VAL_W-1:0]  norm_7,
    output logic                               row_done
);
    import lnso_pkg::*;

    localparam int GMAX   = MAX_ROW_LENGTH / LANES;
    localparam int CNT_W  = $clog2(GMAX + 1);
    localparam int IDX_W  = (GMAX > 1) ? $clog2(GMAX) : 1;
    localparam int N_W    = CNT_W + LANE_SH;
    localparam int SQ_W   = SQL_W + $clog2(MAX_ROW_LENGTH);
    localparam int DVD_W  = (SQ_W > LIM_W) ? SQ_W : LIM_W;
    localparam int WORD_W = LANES * VAL_W;
    localparam int GR_W   = RL_W - LANE_SH;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DRAIN,
        S_MEAN,
        S_VPASS,
        S_VWAIT,
        S_VDIV,
        S_LIM,
        S_SQRT,
        S_EMIT
    } state_t;

    state_t state_reg;

    logic [RL_W-1:0]          row_length_reg;
    logic [CNT_W-1:0]         data_cnt_reg;
    logic [CNT_W-1:0]         wgt_cnt_reg;
    logic [CNT_W-1:0]         issue_cnt_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     mean_neg_reg;
    logic signed [MEAN_W-1:0] mean_reg;
    logic [RSTD_W-1:0]        rstd_reg;

    logic [WORD_W-1:0] row_mem   [GMAX];
    logic [WORD_W-1:0] scale_mem [GMAX];
    logic [WORD_W-1:0] row_rd_reg;
    logic [WORD_W-1:0] scale_rd_reg;
    logic [WORD_W-1:0] in_word;

    lnso_tag_t tag1_reg;
    lnso_tag_t tag2_reg;
    lnso_tag_t tag3_reg;
    lnso_tag_t tag4_reg;

    logic                    out_valid_reg;
    logic                    row_done_reg;
    logic [VAL_W-1:0]        norm_reg [LANES];

    logic [GR_W-1:0]         g_raw;
    logic [CNT_W-1:0]        groups;
    logic [N_W-1:0]          n_elems;
    logic                    in_acc;
    logic [CNT_W-1:0]        data_g;
    logic [CNT_W-1:0]        data_g1;
    logic [CNT_W-1:0]        wgt_g;
    logic [CNT_W-1:0]        wgt_g1;
    logic signed [SUM_W-1:0] lane_total;
    logic signed [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0]        abs_sum;
    logic                    pipe_en;
    logic                    pipe_busy;
    logic                    issuing;
    logic                    issue_last;

    logic                    div_start;
    logic [DVD_W-1:0]        div_dividend;
    logic [DVR_W-1:0]        div_divisor;
    logic                    div_busy;
    logic                    div_done;
    logic [DVD_W-1:0]        div_q;
    logic [MEAN_W-1:0]       mean_mag;

    logic                    sqrt_start;
    logic                    sqrt_done;
    logic [RSTD_W-1:0]       sqrt_root;

    logic                    merge_clear;
    logic [SQ_W-1:0]         sq_acc;
    logic                    merge_done;
    logic [SQL_W-1:0]        lane_sq   [LANES];
    logic [VAL_W-1:0]        lane_norm [LANES];
    lnso_lane_ctl_t          lane_ctl;

    assign in_word = {value_7, value_6, value_5, value_4,
                      value_3, value_2, value_1, value_0};

    // groups per row, at least one and clamped to the store depth
    assign g_raw = row_length_reg[RL_W-1:LANE_SH];
    always_comb
    begin
        if (g_raw == '0)
            groups = CNT_W'(1);
        else if (32'(g_raw) > GMAX)
            groups = CNT_W'(GMAX);
        else
            groups = CNT_W'(g_raw);
    end
    assign n_elems = {groups, {LANE_SH{1'b0}}};

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;

    assign data_g  = (data_cnt_reg >= groups) ? '0 : data_cnt_reg;
    assign data_g1 = data_g + 1'b1;
    assign wgt_g   = (wgt_cnt_reg >= groups) ? '0 : wgt_cnt_reg;
    assign wgt_g1  = wgt_g + 1'b1;

    always_comb
    begin
        lane_total = '0;
        for (int i = 0; i < LANES; i++)
            lane_total = lane_total + SUM_W'($signed(in_word[i*VAL_W +: VAL_W]));
    end
    assign sum_next = sum_reg + lane_total;
    assign abs_sum  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    assign pipe_en    = !out_valid_reg || out_ready;
    assign pipe_busy  = tag1_reg.valid || tag2_reg.valid || tag3_reg.valid || tag4_reg.valid;
    assign issuing    = ((state_reg == S_VPASS) || (state_reg == S_EMIT)) && pipe_en;
    assign issue_last = (issue_cnt_reg == groups - 1'b1);

    assign merge_clear = (state_reg == S_DRAIN) && !pipe_busy;
    assign div_start   = merge_clear
                       || ((state_reg == S_VWAIT) && merge_done)
                       || ((state_reg == S_VDIV) && div_done);
    assign sqrt_start  = (state_reg == S_LIM) && div_done;
    assign mean_mag    = div_q[MEAN_W-1:0];

    always_comb
    begin
        case (state_reg)
            S_DRAIN:
            begin
                div_dividend = DVD_W'(abs_sum);
                div_divisor  = DVR_W'(n_elems);
            end
            S_VWAIT:
            begin
                div_dividend = DVD_W'(sq_acc);
                div_divisor  = DVR_W'(n_elems);
            end
            S_VDIV:
            begin
                div_dividend = DVD_W'(1) << LIM_SHIFT;
                div_divisor  = DVR_W'(div_q[VAR_W-1:0]) + 1'b1;
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    // row and scale stores, one group per word
    always_ff @(posedge clk)
    begin
        if (in_acc && operation == OP_DATA)
            row_mem[data_g[IDX_W-1:0]] <= in_word;
        if (issuing)
            row_rd_reg <= row_mem[issue_cnt_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && operation == OP_SCALE)
            scale_mem[wgt_g[IDX_W-1:0]] <= in_word;
        if (issuing)
            scale_rd_reg <= scale_mem[issue_cnt_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            row_length_reg <= RL_RESET;
            data_cnt_reg   <= '0;
            wgt_cnt_reg    <= '0;
            issue_cnt_reg  <= '0;
            sum_reg        <= '0;
            mean_neg_reg   <= 1'b0;
            mean_reg       <= '0;
            rstd_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                row_length_reg <= cfg_data;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (operation == OP_SCALE)
                        begin
                            wgt_cnt_reg <= (wgt_g1 >= groups) ? '0 : wgt_g1;
                        end
                        else
                        begin
                            sum_reg <= sum_next;
                            if (data_g1 >= groups)
                            begin
                                data_cnt_reg <= '0;
                                state_reg    <= S_DRAIN;
                            end
                            else
                            begin
                                data_cnt_reg <= data_g1;
                            end
                        end
                    end
                end
                S_DRAIN:
                begin
                    if (!pipe_busy)
                    begin
                        mean_neg_reg <= sum_reg[SUM_W-1];
                        sum_reg      <= '0;
                        state_reg    <= S_MEAN;
                    end
                end
                S_MEAN:
                begin
                    if (div_done)
                    begin
                        mean_reg      <= mean_neg_reg ? MEAN_W'(-mean_mag) : MEAN_W'(mean_mag);
                        issue_cnt_reg <= '0;
                        state_reg     <= S_VPASS;
                    end
                end
                S_VPASS:
                begin
                    if (pipe_en)
                    begin
                        issue_cnt_reg <= issue_cnt_reg + 1'b1;
                        if (issue_last)
                            state_reg <= S_VWAIT;
                    end
                end
                S_VWAIT:
                begin
                    if (merge_done)
                        state_reg <= S_VDIV;
                end
                S_VDIV:
                begin
                    if (div_done)
                        state_reg <= S_LIM;
                end
                S_LIM:
                begin
                    if (div_done)
                        state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (sqrt_done)
                    begin
                        rstd_reg      <= sqrt_root;
                        issue_cnt_reg <= '0;
                        state_reg     <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (pipe_en)
                    begin
                        issue_cnt_reg <= issue_cnt_reg + 1'b1;
                        if (issue_last)
                            state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // group pipeline tags and output register, all stalled together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg      <= '0;
            tag2_reg      <= '0;
            tag3_reg      <= '0;
            tag4_reg      <= '0;
            out_valid_reg <= 1'b0;
            row_done_reg  <= 1'b0;
        end
        else if (pipe_en)
        begin
            tag1_reg.valid <= issuing;
            tag1_reg.emit  <= (state_reg == S_EMIT);
            tag1_reg.last  <= issue_last;
            tag2_reg       <= tag1_reg;
            tag3_reg       <= tag2_reg;
            tag4_reg       <= tag3_reg;
            out_valid_reg  <= tag4_reg.valid && tag4_reg.emit;
            row_done_reg   <= tag4_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int i = 0; i < LANES; i++)
                norm_reg[i] <= lane_norm[i];
        end
    end

    assign lane_ctl.en   = pipe_en;
    assign lane_ctl.emit = tag2_reg.emit;

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        lnso_lane u_lane (
            .clk  (clk),
            .ctl  (lane_ctl),
            .x    ($signed(row_rd_reg[i*VAL_W +: VAL_W])),
            .w    ($signed(scale_rd_reg[i*VAL_W +: VAL_W])),
            .mean (mean_reg),
            .rstd (rstd_reg),
            .sq   (lane_sq[i]),
            .norm (lane_norm[i])
        );
    end

    lnso_merge #(
        .SQ_W (SQ_W)
    ) u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (pipe_en),
        .clear (merge_clear),
        .tag   (tag3_reg),
        .sq    (lane_sq),
        .acc   (sq_acc),
        .done  (merge_done)
    );

    lnso_div #(
        .DVD_W (DVD_W),
        .DVR_W (DVR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    lnso_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (div_q[LIM_W-1:0]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign out_valid = out_valid_reg;
    assign row_done  = row_done_reg;
    assign norm_0    = norm_reg[0];
    assign norm_1    = norm_reg[1];
    assign norm_2    = norm_reg[2];
    assign norm_3    = norm_reg[3];
    assign norm_4    = norm_reg[4];
    assign norm_5    = norm_reg[5];
    assign norm_6    = norm_reg[6];
    assign norm_7    = norm_reg[7];

    a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VPASS || state_reg == S_EMIT) |-> issue_cnt_reg < groups)
        else $error("group issue counter beyond row");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_no_early_merge: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_VPASS |-> !merge_done)
        else $error("square sum finished before pass issued");

    a_mean_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MEAN |-> !pipe_busy)
        else $error("mean changes with groups in flight");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// testbench for layer_normalization_scale_only: directed and random rows checked against
// an in-bench normalization predictor; depends on rtl/lnso_pkg.sv and the top-level rtl
module tb;
    import lnso_pkg::*;

    localparam int MAXLEN    = 384;
    localparam int SETTLE    = 400;
    localparam int WD_LIMIT  = 4000;
    localparam int HOLD_LEN  = 300;

    typedef struct packed {
        logic [LANES-1:0][VAL_W-1:0] lanes;
        logic                        done;
    } norm_group_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [RL_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic operation = OP_SCALE;
    logic signed [VAL_W-1:0] val_drv [LANES];
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [VAL_W-1:0] norm_0, norm_1, norm_2, norm_3;
    logic signed [VAL_W-1:0] norm_4, norm_5, norm_6, norm_7;
    logic row_done;

    // predictor state
    logic signed [VAL_W-1:0] row_mem [MAXLEN];
    logic signed [VAL_W-1:0] scale_mem [MAXLEN];
    logic signed [SUM_W-1:0] sum_acc = '0;
    int unsigned data_cnt = 0;
    int unsigned wgt_cnt = 0;
    int unsigned row_len = RL_RESET;

    norm_group_t pending_norms[$];
    int errors = 0;
    logic idle_on = 1'b0;
    logic hold_req = 1'b0;
    int quiet_cycles = 0;

    initial begin
        for (int i = 0; i < LANES; i++)
        begin
            val_drv[i] = '0;
        end
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    layer_normalization_scale_only u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
        .value_0(val_drv[0]), .value_1(val_drv[1]), .value_2(val_drv[2]),
        .value_3(val_drv[3]), .value_4(val_drv[4]), .value_5(val_drv[5]),
        .value_6(val_drv[6]), .value_7(val_drv[7]),
        .out_valid(out_valid), .out_ready(out_ready),
        .norm_0(norm_0), .norm_1(norm_1), .norm_2(norm_2), .norm_3(norm_3),
        .norm_4(norm_4), .norm_5(norm_5), .norm_6(norm_6), .norm_7(norm_7),
        .row_done(row_done)
    );

    function automatic int unsigned row_groups();
        int unsigned g;
        begin
            g = row_len / LANES;
            if (g < 1) g = 1;
            if (g > MAXLEN / LANES) g = MAXLEN / LANES;
            return g;
        end
    endfunction

    function automatic longint unsigned inv_root(longint unsigned v);
        longint unsigned lim;
        longint unsigned r;
        longint unsigned c;
        begin
            lim = (64'd1 << 48) / v;
            r = 0;
            for (int b = 24; b >= 0; b--)
            begin
                c = r | (64'd1 << b);
                if (c * c <= lim) r = c;
            end
            return r;
        end
    endfunction

    function automatic logic [VAL_W-1:0] scaled_lane(longint d, longint unsigned rstd,
                                                    longint w);
        logic neg;
        longint unsigned md;
        longint unsigned mw;
        longint unsigned mag;
        begin
            neg = (d < 0) != (w < 0);
            md = (d < 0) ? -d : d;
            mw = (w < 0) ? -w : w;
            mag = (md * rstd * mw + (64'd1 << 27)) >> 28;
            if (neg) return (mag > 32768) ? 16'h8000 : 16'(-longint'(mag));
            return (mag > 32767) ? 16'h7fff : 16'(mag);
        end
    endfunction

    task automatic normalize_row(int unsigned groups);
        int unsigned n;
        longint mean;
        longint d;
        longint unsigned sq;
        longint unsigned rstd;
        norm_group_t grp;
        begin
            n = groups * LANES;
            mean = longint'(sum_acc) / longint'(n);
            sq = 0;
            for (int i = 0; i < n; i++)
            begin
                d = longint'(row_mem[i]) - mean;
                sq += d * d;
            end
            rstd = inv_root(sq / n + 1);
            for (int g = 0; g < groups; g++)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    grp.lanes[l] = scaled_lane(longint'(row_mem[g*LANES+l]) - mean, rstd,
                                               longint'(scale_mem[g*LANES+l]));
                end
                grp.done = (g + 1 == groups);
                pending_norms = {pending_norms, grp};
            end
        end
    endtask

    task automatic predict_item(logic op, logic signed [VAL_W-1:0] v [LANES]);
        int unsigned groups;
        int unsigned g;
        begin
            groups = row_groups();
            if (op == OP_SCALE)
            begin
                g = (wgt_cnt >= groups) ? 0 : wgt_cnt;
                for (int l = 0; l < LANES; l++) scale_mem[g*LANES+l] = v[l];
                g++;
                wgt_cnt = (g >= groups) ? 0 : g;
            end
            else
            begin
                g = (data_cnt >= groups) ? 0 : data_cnt;
                for (int l = 0; l < LANES; l++)
                begin
                    row_mem[g*LANES+l] = v[l];
                    sum_acc = sum_acc + SUM_W'(v[l]);
                end
                g++;
                if (g < groups) data_cnt = g;
                else
                begin
                    normalize_row(groups);
                    data_cnt = 0;
                    sum_acc = '0;
                end
            end
        end
    endtask

    task automatic send_item(logic op, logic signed [VAL_W-1:0] v [LANES]);
        begin
            if (idle_on && $urandom_range(99) < 35)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            predict_item(op, v);
            in_valid <= 1'b1;
            operation <= op;
            for (int l = 0; l < LANES; l++) val_drv[l] <= v[l];
            do @(posedge clk); while (!in_ready);
        end
    endtask

    task automatic drain();
        begin
            in_valid <= 1'b0;
            while (pending_norms.size() != 0) @(posedge clk);
        end
    endtask

    task automatic write_row_length(int unsigned len);
        begin
            drain();
            repeat (SETTLE) @(posedge clk);
            cfg_valid <= 1'b1;
            cfg_data <= RL_W'(len);
            do @(posedge clk); while (!cfg_ready);
            cfg_valid <= 1'b0;
            row_len = len & 9'h1ff;
        end
    endtask

    task automatic fill_value(output logic signed [VAL_W-1:0] v [LANES], input int mode);
        logic signed [VAL_W-1:0] base;
        begin
            base = VAL_W'($urandom);
            for (int l = 0; l < LANES; l++)
            begin
                case (mode)
                    0: v[l] = VAL_W'($urandom);
                    1: v[l] = VAL_W'($signed($urandom_range(1023)) - 512);
                    2: v[l] = base + VAL_W'($urandom_range(15));
                    default: v[l] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                endcase
            end
        end
    endtask

    task automatic load_scales(int mode);
        logic signed [VAL_W-1:0] v [LANES];
        begin
            for (int g = 0; g < row_groups(); g++)
            begin
                fill_value(v, mode);
                send_item(OP_SCALE, v);
            end
        end
    endtask

    task automatic send_const(logic op, logic signed [VAL_W-1:0] a,
                              logic signed [VAL_W-1:0] b);
        logic signed [VAL_W-1:0] v [LANES];
        begin
            for (int l = 0; l < LANES; l++) v[l] = l[0] ? b : a;
            send_item(op, v);
        end
    endtask

    task automatic test_extremes();
        begin
            write_row_length(8);
            send_const(OP_SCALE, 16'sh1000, 16'sh8000);
            send_const(OP_DATA, 16'sh0000, 16'sh0000);
            send_const(OP_DATA, 16'sh7fff, 16'sh7fff);
            send_const(OP_DATA, 16'sh7fff, 16'sh8000);
            send_const(OP_DATA, 16'sh0001, 16'shffff);
            send_const(OP_SCALE, 16'sh7fff, 16'sh0000);
            send_const(OP_DATA, 16'sh5555, 16'shaaaa);
            send_const(OP_DATA, 16'sh0000, 16'sh0001);
        end
    endtask

    task automatic test_clamped_lengths();
        begin
            write_row_length(0);
            send_const(OP_SCALE, 16'sh8000, 16'sh7fff);
            send_const(OP_DATA, 16'sh0100, 16'shff00);
            write_row_length(21);
            load_scales(0);
            send_const(OP_DATA, 16'sh8000, 16'sh8000);
            send_const(OP_DATA, 16'sh7fff, 16'sh7fff);
        end
    endtask

    task automatic test_shrink_mid_row();
        begin
            write_row_length(24);
            load_scales(1);
            send_const(OP_DATA, 16'sh0400, 16'sh0123);
            send_const(OP_DATA, 16'shfc00, 16'sh0321);
            write_row_length(8);
            send_const(OP_DATA, 16'sh0010, 16'sh0020);
        end
    endtask

    task automatic test_backpressure();
        logic signed [VAL_W-1:0] v [LANES];
        begin
            write_row_length(16);
            load_scales(0);
            hold_req <= 1'b1;
            for (int i = 0; i < 8; i++)
            begin
                fill_value(v, i % 3);
                send_item(OP_DATA, v);
            end
            drain();
        end
    endtask

    task automatic test_random(int budget);
        logic signed [VAL_W-1:0] v [LANES];
        int unsigned lens [6] = '{8, 16, 24, 40, 72, 32};
        int sent;
        int mode;
        int count;
        begin
            sent = 0;
            mode = 0;
            idle_on = 1'b0;
            while (sent < budget)
            begin
                write_row_length(lens[$urandom_range(5)]);
                load_scales($urandom_range(2));
                count = $urandom_range(6, 12);
                for (int i = 0; i < count; i++)
                begin
                    if (data_cnt == 0) mode = $urandom_range(3);
                    fill_value(v, mode);
                    send_item(($urandom_range(99) < 85) ? OP_DATA : OP_SCALE, v);
                    sent++;
                end
                if (sent > budget / 3) idle_on = 1'b1;
            end
        end
    endtask

    task automatic test_full_row();
        logic signed [VAL_W-1:0] v [LANES];
        begin
            write_row_length(384);
            load_scales(0);
            for (int i = 0; i < 24; i++)
            begin
                fill_value(v, 0);
                send_item(OP_DATA, v);
            end
            write_row_length(511);
            for (int i = 0; i < 24; i++)
            begin
                fill_value(v, 3);
                send_item(OP_DATA, v);
            end
        end
    endtask

    task automatic report_mismatch(string what, norm_group_t got, norm_group_t want);
        begin
            errors++;
            $display("mismatch %s: got %h/%b want %h/%b", what, got.lanes, got.done,
                     want.lanes, want.done);
        end
    endtask

    // result side: ready idling, long hold, and checking
    int hold_left = 0;
    logic hold_done = 1'b0;
    always @(posedge clk)
    begin
        norm_group_t got;
        norm_group_t want;
        if (out_valid && out_ready)
        begin
            got.lanes = {norm_7, norm_6, norm_5, norm_4, norm_3, norm_2, norm_1, norm_0};
            got.done = row_done;
            if (pending_norms.size() == 0)
            begin
                report_mismatch("unexpected item", got, '0);
            end
            else
            begin
                want = pending_norms.pop_front();
                if (got != want) report_mismatch("norm", got, want);
            end
        end
        if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= !(idle_on && $urandom_range(99) < 35);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WD_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_clamped_lengths();
        test_shrink_mid_row();
        test_backpressure();
        test_random(12);
        test_full_row();
        drain();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
        begin
            $display("tb: clean");
        end
        else
        begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
